@@ design/kctt_pkg.sv @@
// ----------------------------------------------------------------------------
// kctt_pkg
// Shared types and constants of the keyed countdown timer table.
// ----------------------------------------------------------------------------
package kctt_pkg;

  localparam int TABLE_SIZE_DEF = 16;
  localparam int RESULT_CAP     = 16;

  localparam logic [31:0] FREE_MARK = 32'hFFFF_FFFF;

  localparam logic [1:0] ST_ZERO    = 2'd0;
  localparam logic [1:0] ST_NOLOCAL = 2'd1;
  localparam logic [1:0] ST_STORED  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;

  localparam logic REQ_RECALL = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic CFG_WAY_COUNT = 1'b0;
  localparam logic CFG_EP_BASE   = 1'b1;

  typedef struct packed {
    logic [7:0]  endpoint;
    logic [15:0] group;
    logic [7:0]  scene;
    logic [31:0] remaining;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REQ_SCAN,
    S_REQ_DONE,
    S_TICK_SCAN,
    S_EMIT_RD,
    S_EMIT_EV
  } state_t;

endpackage

@@ design/kctt_ram.sv @@
// ----------------------------------------------------------------------------
// kctt_ram
// Timer entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kctt_ram #(
  parameter int DEPTH = kctt_pkg::TABLE_SIZE_DEF,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic [IW-1:0]    rd_addr,
  output kctt_pkg::entry_t rd_data,
  input  logic             wr_en,
  input  logic [IW-1:0]    wr_addr,
  input  kctt_pkg::entry_t wr_data
);

  kctt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/keyed_countdown_timer_table.sv @@
// A request scans the whole table, then answers in one beat.
// A tick scans the table once to age it, then walks the entries to emit
// notices, and each notice can be held by an output stall.
// One item at a time: no new input is taken until the block is idle again;
// the single read port of the entry RAM sets the pace of every scan.
// Reset (synchronous, rst_n low) frees all entries through valid flops.
// ----------------------------------------------------------------------------
// keyed_countdown_timer_table
// Keyed countdown timers with recall requests and elapsed-time ticks.
// ----------------------------------------------------------------------------
module keyed_countdown_timer_table #(
  parameter int TABLE_SIZE = kctt_pkg::TABLE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // in_endpoint, in_group, in_scene, time_ms
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // status, out_endpoint, out_group, out_scene,
                                  // next_delay, zero pad
  output logic        out_tuser,  // result_kind
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam logic [CW-1:0] N_C = CW'(TABLE_SIZE);

  kctt_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  pv_r, pv_nxt;
  logic [IW-1:0]         pidx_r, pidx_nxt;
  logic                  store_r, store_nxt;
  logic [1:0]            pre_st_r, pre_st_nxt;
  logic [7:0]            ep_r, ep_nxt;
  logic [15:0]           grp_r, grp_nxt;
  logic [7:0]            sc_r, sc_nxt;
  logic [31:0]           t_r, t_nxt;
  logic                  found_r, found_nxt;
  logic [IW-1:0]         hit_r, hit_nxt;
  logic                  ffound_r, ffound_nxt;
  logic [IW-1:0]         free_r, free_nxt;
  logic [31:0]           min_r, min_nxt;
  logic [CW-1:0]         zeros_r, zeros_nxt;
  logic [CW-1:0]         total_r, total_nxt;
  logic [CW-1:0]         n_r, n_nxt;
  logic [TABLE_SIZE-1:0] valid_r, valid_nxt;
  logic [4:0]            way_r;
  logic [7:0]            base_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            o_st_r, o_st_nxt;
  logic [7:0]            o_ep_r, o_ep_nxt;
  logic [15:0]           o_grp_r, o_grp_nxt;
  logic [7:0]            o_sc_r, o_sc_nxt;
  logic [31:0]           o_nd_r, o_nd_nxt;
  logic                  o_kind_r, o_kind_nxt;
  logic                  o_last_r, o_last_nxt;

  logic [IW-1:0]         ra, wa;
  logic                  we;
  kctt_pkg::entry_t      rd_data, wd;

  logic                  in_acc, out_free, scan_done, ev_zero, emit_load, emit_last;
  logic                  is_local, match, e_valid;
  logic [7:0]            i_ep, i_sc, ep_off;
  logic [15:0]           i_grp;
  logic [31:0]           i_t, dec;

  kctt_ram #(.DEPTH(TABLE_SIZE), .IW(IW)) u_ram (
    .clk     (clk),
    .rd_addr (ra),
    .rd_data (rd_data),
    .wr_en   (we),
    .wr_addr (wa),
    .wr_data (wd)
  );

  assign i_ep  = in_tdata[7:0];
  assign i_grp = in_tdata[23:8];
  assign i_sc  = in_tdata[31:24];
  assign i_t   = in_tdata[63:32];

  assign in_tready = (state_r == kctt_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign scan_done = (cnt_r == N_C) && !pv_r;

  assign ep_off   = i_ep - base_r;
  assign is_local = (i_ep >= base_r) && (ep_off < {3'b000, way_r});

  assign e_valid = valid_r[pidx_r];
  assign match   = store_r && valid_r[pidx_r] && (rd_data.endpoint == ep_r) &&
                   (rd_data.group == grp_r) && (rd_data.scene == sc_r);
  assign dec     = (rd_data.remaining < t_r) ? 32'd0 : rd_data.remaining - t_r;

  assign ev_zero   = valid_r[cnt_r[IW-1:0]] && (rd_data.remaining == 32'd0);
  assign emit_load = (state_r == kctt_pkg::S_EMIT_EV) && ev_zero && out_free;
  assign emit_last = (({1'b0, n_r} + 1'b1) == {1'b0, total_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kctt_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == kctt_pkg::REQ_TICK) ? kctt_pkg::S_TICK_SCAN
                                                       : kctt_pkg::S_REQ_SCAN;
        end
      end
      kctt_pkg::S_REQ_SCAN: begin
        if (scan_done) state_nxt = kctt_pkg::S_REQ_DONE;
      end
      kctt_pkg::S_REQ_DONE: begin
        if (out_free) state_nxt = kctt_pkg::S_IDLE;
      end
      kctt_pkg::S_TICK_SCAN: begin
        if (scan_done) begin
          state_nxt = (zeros_r == '0) ? kctt_pkg::S_IDLE : kctt_pkg::S_EMIT_RD;
        end
      end
      kctt_pkg::S_EMIT_RD: state_nxt = kctt_pkg::S_EMIT_EV;
      kctt_pkg::S_EMIT_EV: begin
        if (!ev_zero) begin
          state_nxt = kctt_pkg::S_EMIT_RD;
        end else if (out_free) begin
          state_nxt = emit_last ? kctt_pkg::S_IDLE : kctt_pkg::S_EMIT_RD;
        end
      end
      default: state_nxt = kctt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    store_nxt     = store_r;
    pre_st_nxt    = pre_st_r;
    ep_nxt        = ep_r;
    grp_nxt       = grp_r;
    sc_nxt        = sc_r;
    t_nxt         = t_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    ffound_nxt    = ffound_r;
    free_nxt      = free_r;
    min_nxt       = min_r;
    zeros_nxt     = zeros_r;
    total_nxt     = total_r;
    n_nxt         = n_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_st_nxt      = o_st_r;
    o_ep_nxt      = o_ep_r;
    o_grp_nxt     = o_grp_r;
    o_sc_nxt      = o_sc_r;
    o_nd_nxt      = o_nd_r;
    o_kind_nxt    = o_kind_r;
    o_last_nxt    = o_last_r;
    ra            = cnt_r[IW-1:0];
    we            = 1'b0;
    wa            = pidx_r;
    wd            = rd_data;

    unique case (state_r)
      kctt_pkg::S_IDLE: begin
        if (in_acc) begin
          ep_nxt     = i_ep;
          grp_nxt    = i_grp;
          sc_nxt     = i_sc;
          t_nxt      = i_t;
          if ((in_tuser == kctt_pkg::REQ_RECALL) && (i_t == kctt_pkg::FREE_MARK)) begin
            t_nxt = kctt_pkg::FREE_MARK - 32'd1;
          end
          pre_st_nxt = (i_t == 32'd0) ? kctt_pkg::ST_ZERO : kctt_pkg::ST_NOLOCAL;
          store_nxt  = (in_tuser == kctt_pkg::REQ_RECALL) && (i_t != 32'd0) && is_local;
          cnt_nxt    = '0;
          found_nxt  = 1'b0;
          ffound_nxt = 1'b0;
          min_nxt    = kctt_pkg::FREE_MARK;
          zeros_nxt  = '0;
        end
      end
      kctt_pkg::S_REQ_SCAN, kctt_pkg::S_TICK_SCAN: begin
        if (cnt_r != N_C) begin
          cnt_nxt  = cnt_r + 1'b1;
          pv_nxt   = 1'b1;
          pidx_nxt = cnt_r[IW-1:0];
        end
        if (pv_r && (state_r == kctt_pkg::S_REQ_SCAN)) begin
          if (match && !found_r) begin
            found_nxt = 1'b1;
            hit_nxt   = pidx_r;
          end
          if (!e_valid && !ffound_r) begin
            ffound_nxt = 1'b1;
            free_nxt   = pidx_r;
          end
          if (e_valid && !match && (rd_data.remaining < min_r)) begin
            min_nxt = rd_data.remaining;
          end
        end
        if (pv_r && (state_r == kctt_pkg::S_TICK_SCAN) && e_valid) begin
          we           = 1'b1;
          wd.remaining = dec;
          if (dec == 32'd0) begin
            zeros_nxt = zeros_r + 1'b1;
          end else if (dec < min_r) begin
            min_nxt = dec;
          end
        end
        if (scan_done && (state_r == kctt_pkg::S_TICK_SCAN)) begin
          cnt_nxt = '0;
          n_nxt   = '0;
          if (32'(zeros_r) > 32'(kctt_pkg::RESULT_CAP)) begin
            total_nxt = CW'(kctt_pkg::RESULT_CAP);
            min_nxt   = 32'd0;
          end else begin
            total_nxt = zeros_r;
          end
        end
      end
      kctt_pkg::S_REQ_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = kctt_pkg::KIND_ANSWER;
          o_ep_nxt      = '0;
          o_grp_nxt     = '0;
          o_sc_nxt      = '0;
          o_last_nxt    = 1'b1;
          o_nd_nxt      = min_r;
          o_st_nxt      = pre_st_r;
          if (store_r) begin
            if (found_r || ffound_r) begin
              o_st_nxt     = kctt_pkg::ST_STORED;
              we           = 1'b1;
              wa           = found_r ? hit_r : free_r;
              wd.endpoint  = ep_r;
              wd.group     = grp_r;
              wd.scene     = sc_r;
              wd.remaining = t_r;
              valid_nxt[wa] = 1'b1;
              if (t_r < min_r) o_nd_nxt = t_r;
            end else begin
              o_st_nxt = kctt_pkg::ST_FULL;
            end
          end
        end
      end
      kctt_pkg::S_EMIT_RD: begin
      end
      kctt_pkg::S_EMIT_EV: begin
        if (!ev_zero) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (out_free) begin
          cnt_nxt       = cnt_r + 1'b1;
          n_nxt         = n_r + 1'b1;
          valid_nxt[cnt_r[IW-1:0]] = 1'b0;
          out_valid_nxt = 1'b1;
          o_kind_nxt    = kctt_pkg::KIND_NOTICE;
          o_st_nxt      = kctt_pkg::ST_ZERO;
          o_ep_nxt      = rd_data.endpoint;
          o_grp_nxt     = rd_data.group;
          o_sc_nxt      = rd_data.scene;
          o_nd_nxt      = min_r;
          o_last_nxt    = emit_last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kctt_pkg::S_IDLE;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      way_r       <= 5'd1;
      base_r      <= 8'd1;
      store_r     <= 1'b0;
      found_r     <= 1'b0;
      ffound_r    <= 1'b0;
      zeros_r     <= '0;
      total_r     <= '0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      store_r     <= store_nxt;
      found_r     <= found_nxt;
      ffound_r    <= ffound_nxt;
      zeros_r     <= zeros_nxt;
      total_r     <= total_nxt;
      n_r         <= n_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == kctt_pkg::CFG_WAY_COUNT) way_r <= cfg_data[4:0];
        if (cfg_index == kctt_pkg::CFG_EP_BASE)   base_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r   <= pidx_nxt;
    pre_st_r <= pre_st_nxt;
    ep_r     <= ep_nxt;
    grp_r    <= grp_nxt;
    sc_r     <= sc_nxt;
    t_r      <= t_nxt;
    hit_r    <= hit_nxt;
    free_r   <= free_nxt;
    min_r    <= min_nxt;
    o_st_r   <= o_st_nxt;
    o_ep_r   <= o_ep_nxt;
    o_grp_r  <= o_grp_nxt;
    o_sc_r   <= o_sc_nxt;
    o_nd_r   <= o_nd_nxt;
    o_kind_r <= o_kind_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {6'd0, o_nd_r, o_sc_r, o_grp_r, o_ep_r, o_st_r};

`ifndef SYNTHESIS
  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |-> (n_r < total_r))
    else $error("notice beyond expected count");

  a_answer_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == kctt_pkg::KIND_ANSWER)) |-> out_tlast)
    else $error("request answer without last");

  a_emit_frees: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |=> !valid_r[$past(cnt_r[IW-1:0])])
    else $error("emitted entry not freed");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken while busy");
`endif

endmodule
